// File: rtl/core/rtsdf_pkg.sv
// rtsdf_pkg: shared types and constants of the tsdf measurement block
// used by rtsdf_front, rtsdf_back and rtp_tsdf_measure; depends on nothing
`default_nettype none

package rtsdf_pkg;

  // field widths fixed by the packet format
  localparam int unsigned TS_W    = 32;
  localparam int unsigned FS_W    = 16;
  localparam int unsigned US_W    = 63;
  localparam int unsigned WIN_W   = 26;
  // clock_rate * channel_count * bytes per sample fits in 27 bits
  localparam int unsigned NUM_W   = 27;
  localparam int unsigned CRATE_W = 18;
  localparam int unsigned CHAN_W  = 7;
  localparam int unsigned FMT_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  // sample format codes
  localparam logic [FMT_W-1:0] FMT_L16 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_L24 = 2'd1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd2;

  typedef struct packed {
    logic [CRATE_W-1:0] clock_rate;
    logic [CHAN_W-1:0]  channel_count;
    logic [FMT_W-1:0]   sample_format;
  } cfg_t;

  // fixed part of a queued packet; the delay travels beside it
  typedef struct packed {
    logic [TS_W-1:0]  delta;
    logic             crossed;
    logic [NUM_W-1:0] numerator;
    logic [FS_W-1:0]  frame_size;
  } q_item_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_WIN  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/rtsdf_fifo.sv
// rtsdf_fifo: two-entry queue between the packet front end and the back end
// generic data width; uses no package
`default_nettype none

module rtsdf_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   not_full,
  output logic                   not_empty,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtsdf_front.sv
// rtsdf_front: accepts packets, tracks the rtp timestamp and classifies by format
// depends on rtsdf_pkg
`default_nettype none

module rtsdf_front
  import rtsdf_pkg::*;
#(
  parameter int unsigned TIME_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [US_W-1:0]       presentation_us,
  input  wire logic [US_W-1:0]       transmission_us,
  input  wire logic [TS_W-1:0]       rtp_timestamp,
  input  wire logic [FS_W-1:0]       frame_size,
  input  wire logic                  q_not_full,
  output logic                       q_push,
  output q_item_t                    q_item,
  output logic [TIME_BITS-1:0]       q_delay
);

  logic [TS_W-1:0]            last_timestamp;
  logic                       fmt_ok;
  logic [CRATE_W+CHAN_W-1:0]  prod;
  logic [NUM_W-1:0]           prod_ext;
  logic [63:0]                diff;

  assign in_ready = q_not_full;

  always_comb begin
    prod     = CRATE_W'(cfg.clock_rate) * (CRATE_W+CHAN_W)'(cfg.channel_count);
    prod_ext = NUM_W'(prod);
    fmt_ok   = 1'b1;
    q_item.numerator = '0;
    unique case (cfg.sample_format)
      FMT_L16: q_item.numerator = prod_ext << 1;
      FMT_L24: q_item.numerator = (prod_ext << 1) + prod_ext;
      default: fmt_ok = 1'b0;
    endcase
    q_item.delta      = rtp_timestamp - last_timestamp;
    q_item.crossed    = (last_timestamp > rtp_timestamp);
    q_item.frame_size = frame_size;
    diff    = {1'b0, presentation_us} - {1'b0, transmission_us};
    q_delay = diff[TIME_BITS-1:0];
  end

  // other formats still move the timestamp but are dropped here
  assign q_push = in_valid && in_ready && fmt_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_timestamp <= '0;
    end else if (in_valid && in_ready) begin
      last_timestamp <= rtp_timestamp;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtsdf_back.sv
// rtsdf_back: window length divider, deviation tracking and result register
// depends on rtsdf_pkg
`default_nettype none

module rtsdf_back
  import rtsdf_pkg::*;
#(
  parameter int unsigned TIME_BITS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_not_empty,
  output logic                         q_pop,
  input  wire q_item_t                 q_item,
  input  wire logic [TIME_BITS-1:0]    q_delay,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [TS_W-1:0]       timestamp_delta,
  output logic                         epoch_crossed,
  output logic [US_W-1:0]              tsdf_us,
  output logic signed [63:0]           latency_us
);

  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

  back_state_t        state;
  logic [TS_W-1:0]    delta;
  logic               crossed;
  logic signed [63:0] delay;
  logic [FS_W-1:0]    fsize;
  logic [FS_W-1:0]    rem;
  logic [NUM_W-1:0]   quo;
  logic [4:0]         bit_cnt;
  logic signed [63:0] dev;

  logic               ref_valid;
  logic signed [63:0] ref_delay;
  logic signed [63:0] dev_max;
  logic signed [63:0] dev_min;
  logic [WIN_W-1:0]   win_cnt;
  logic [US_W-1:0]    delay_factor;

  logic [FS_W:0]      trial;
  logic               ge;
  logic [WIN_W-1:0]   win;
  logic               restart;
  logic [64:0]        spread_diff;
  logic [US_W-1:0]    spread;
  logic [64:0]        dev_diff;
  logic signed [63:0] dev_sat;
  logic               out_load;

  always_comb begin
    // one restoring division step
    trial = {rem, quo[NUM_W-1]};
    ge    = (trial >= {1'b0, fsize});

    win     = (quo > NUM_W'(WIN_MAX)) ? WIN_MAX : quo[WIN_W-1:0];
    restart = !ref_valid || (win_cnt == win);

    spread_diff = {dev_max[63], dev_max} - {dev_min[63], dev_min};
    if (spread_diff[64]) begin
      spread = '0;
    end else if (spread_diff[63]) begin
      spread = '1;
    end else begin
      spread = spread_diff[US_W-1:0];
    end

    dev_diff = {delay[63], delay} - {ref_delay[63], ref_delay};
    if (dev_diff[64] != dev_diff[63]) begin
      dev_sat = dev_diff[64] ? S64_MIN : S64_MAX;
    end else begin
      dev_sat = dev_diff[63:0];
    end
  end

  assign q_pop    = (state == ST_IDLE) && q_not_empty;
  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ref_valid    <= 1'b0;
      ref_delay    <= '0;
      dev_max      <= S64_MIN;
      dev_min      <= S64_MAX;
      win_cnt      <= '0;
      delay_factor <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            rem     <= '0;
            bit_cnt <= 5'(NUM_W - 1);
            if (q_item.frame_size == '0) begin
              quo   <= NUM_W'(WIN_MAX);
              state <= ST_WIN;
            end else begin
              quo   <= q_item.numerator;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem     <= ge ? FS_W'(trial - {1'b0, fsize}) : trial[FS_W-1:0];
          quo     <= {quo[NUM_W-2:0], ge};
          bit_cnt <= bit_cnt - 5'd1;
          if (bit_cnt == 5'd0) begin
            state <= ST_WIN;
          end
        end
        ST_WIN: begin
          if (restart) begin
            delay_factor <= spread;
            ref_delay    <= delay;
            ref_valid    <= 1'b1;
            dev_max      <= S64_MIN;
            dev_min      <= S64_MAX;
            win_cnt      <= WIN_W'(1);
            state        <= ST_FIN;
          end else begin
            dev     <= dev_sat;
            win_cnt <= win_cnt + WIN_W'(1);
            state   <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (dev > dev_max) begin
            dev_max <= dev;
          end
          if (dev < dev_min) begin
            dev_min <= dev;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-packet payload captured at pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      delta   <= q_item.delta;
      crossed <= q_item.crossed;
      delay   <= 64'($signed(q_delay));
      fsize   <= q_item.frame_size;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      timestamp_delta <= delta;
      epoch_crossed   <= crossed;
      tsdf_us         <= delay_factor;
      latency_us      <= delay;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtp_tsdf_measure.sv
// rtp_tsdf_measure: top level of the timestamped delay factor measurement
// depends on rtsdf_pkg, rtsdf_front, rtsdf_fifo, rtsdf_back
`default_nettype none

// timestamped delay factor (tsdf) of an audio rtp stream. each input word is
// one received packet; every packet of format l16 or l24 yields one output
// word with the wrapped rtp timestamp delta, an epoch crossing flag, the
// latency (presentation minus transmission, wrapped to TIME_BITS and sign
// extended) and the tsdf of the last completed window. packets of any other
// format update the timestamp tracking and yield no output word. the front
// end takes a packet every cycle while its two-entry queue has room; the back
// end works on one packet at a time: it pops the packet, runs the bit-serial
// window length divider (skipped for a zero frame size), makes the window
// decision, updates the deviation (skipped when a window restarts) and loads
// the output register, which waits while the receiver holds off; only then
// does it pop the next packet. configuration writes are taken every cycle and
// must only be made while no packet is in flight.
module rtp_tsdf_measure
  import rtsdf_pkg::*;
#(
  parameter int unsigned TIME_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // packet input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [US_W-1:0]       presentation_us,
  input  wire logic [US_W-1:0]       transmission_us,
  input  wire logic [TS_W-1:0]       rtp_timestamp,
  input  wire logic [FS_W-1:0]       frame_size,
  // result output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [TS_W-1:0]     timestamp_delta,
  output logic                       epoch_crossed,
  output logic [US_W-1:0]            tsdf_us,
  output logic signed [63:0]         latency_us
);

  localparam int unsigned Q_W = $bits(q_item_t) + TIME_BITS;

  cfg_t                 cfg;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_not_full;
  logic                 q_not_empty;
  q_item_t              front_item;
  logic [TIME_BITS-1:0] front_delay;
  logic [Q_W-1:0]       q_rd_data;
  q_item_t              back_item;
  logic [TIME_BITS-1:0] back_delay;

  // registers are always writable; writes to the unused index are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_rate    <= CRATE_W'(48000);
      cfg.channel_count <= CHAN_W'(2);
      cfg.sample_format <= FMT_L24;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLOCK_RATE:    cfg.clock_rate    <= cfg_data[CRATE_W-1:0];
        CFG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[CHAN_W-1:0];
        CFG_SAMPLE_FORMAT: cfg.sample_format <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: timestamp tracking, latency and window numerator
  rtsdf_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .presentation_us (presentation_us),
    .transmission_us (transmission_us),
    .rtp_timestamp   (rtp_timestamp),
    .frame_size      (frame_size),
    .q_not_full      (q_not_full),
    .q_push          (q_push),
    .q_item          (front_item),
    .q_delay         (front_delay)
  );

  // short queue so the front end keeps taking packets while the back end works
  rtsdf_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({front_item, front_delay}),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_data  (q_rd_data)
  );

  assign back_item  = q_rd_data[Q_W-1:TIME_BITS];
  assign back_delay = q_rd_data[TIME_BITS-1:0];

  // back end: serial divider, window restart and min/max deviation
  rtsdf_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_pop           (q_pop),
    .q_item          (back_item),
    .q_delay         (back_delay),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .timestamp_delta (timestamp_delta),
    .epoch_crossed   (epoch_crossed),
    .tsdf_us         (tsdf_us),
    .latency_us      (latency_us)
  );

endmodule

`default_nettype wire

// File: verif/tb_rtp_tsdf_measure.sv
`timescale 1ns / 1ps
// tb_rtp_tsdf_measure: self-checking testbench of the rtp tsdf measurement block
// depends on rtsdf_pkg and rtp_tsdf_measure; a built-in predictor checks each word

module tb_rtp_tsdf_measure;
  import rtsdf_pkg::*;

  // quiet cycles allowed for packets still in the back end (up to four in
  // flight) before a register write or the end
  localparam int unsigned SETTLE_CYCLES  = 150;
  // long receiver hold-off, well past the time it takes to fill the block
  localparam int unsigned LONG_HOLD      = 300;
  // no handshake for this long means the block hung
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // result words to collect in the random part
  localparam int unsigned RANDOM_WORDS   = 640;
  // register values after reset
  localparam logic [CRATE_W-1:0] RESET_RATE  = 18'd48000;
  localparam logic [CHAN_W-1:0]  RESET_CHANS = 7'd2;
  // any format code other than l16 and l24 yields no word
  localparam logic [FMT_W-1:0]   FMT_OTHER   = 2'd2;
  localparam logic [US_W-1:0]    US_MAX      = '1;
  localparam logic signed [63:0] S64_MIN     = {1'b1, 63'd0};
  localparam logic signed [63:0] S64_MAX     = {1'b0, {63{1'b1}}};

  // one result word as the block presents it
  typedef struct {
    logic signed [TS_W-1:0] delta;
    logic                   crossed;
    logic [US_W-1:0]        tsdf;
    logic signed [63:0]     latency;
  } tsdf_word_t;

  // one row of the directed table: register setting, packet, and optionally
  // the word read straight off the spec
  typedef struct {
    logic [CRATE_W-1:0] rate;
    logic [CHAN_W-1:0]  chans;
    logic [FMT_W-1:0]   fmt;
    logic [US_W-1:0]    pres;
    logic [US_W-1:0]    trans;
    logic [TS_W-1:0]    ts;
    logic [FS_W-1:0]    fs;
    bit                 typed;
    tsdf_word_t         want;
  } packet_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and ports of the block
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [US_W-1:0]       presentation_us = '0;
  logic [US_W-1:0]       transmission_us = '0;
  logic [TS_W-1:0]       rtp_timestamp   = '0;
  logic [FS_W-1:0]       frame_size      = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [TS_W-1:0] timestamp_delta;
  logic                  epoch_crossed;
  logic [US_W-1:0]       tsdf_us;
  logic signed [63:0]    latency_us;

  always #5 clk = ~clk;

  // default TIME_BITS of 64: the latency is the plain 64-bit difference
  rtp_tsdf_measure uut (.*);

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the registers and the window tracking
  // ---------------------------------------------------------------------------
  logic [CRATE_W-1:0] p_rate;
  logic [CHAN_W-1:0]  p_chans;
  logic [FMT_W-1:0]   p_fmt;
  logic [TS_W-1:0]    prev_ts;
  logic signed [63:0] win_ref_delay;
  bit                 win_open;
  logic signed [63:0] dev_hi;
  logic signed [63:0] dev_lo;
  logic [WIN_W-1:0]   win_count;
  logic [US_W-1:0]    tsdf_hold;

  tsdf_word_t  pending_words[$];
  packet_row_t packet_rows[$];

  // run statistics
  int unsigned mismatches      = 0;
  int unsigned words_checked   = 0;
  int unsigned packets_sent    = 0;
  int unsigned settings_used   = 0;
  int unsigned window_restarts = 0;
  int unsigned nonzero_tsdf    = 0;
  int unsigned epoch_wraps     = 0;

  // idling control shared by both sides; hold_token bumps ask for a long hold
  int unsigned idle_pct   = 10;
  int unsigned hold_token = 0;

  function automatic void reset_predictor();
    p_rate        = RESET_RATE;
    p_chans       = RESET_CHANS;
    p_fmt         = FMT_L24;
    prev_ts       = '0;
    win_ref_delay = '0;
    win_open      = 1'b0;
    dev_hi        = S64_MIN;
    dev_lo        = S64_MAX;
    win_count     = '0;
    tsdf_hold     = '0;
  endfunction

  // advances the predictor by one packet; returns 1 when the packet yields a word
  function automatic bit predict_tsdf(input logic [US_W-1:0] pres,
                                      input logic [US_W-1:0] trans,
                                      input logic [TS_W-1:0] ts,
                                      input logic [FS_W-1:0] fs,
                                      output tsdf_word_t w);
    logic [63:0]        bps;
    logic [63:0]        num;
    logic [63:0]        win;
    logic [63:0]        raw;
    logic signed [63:0] delay;
    logic signed [63:0] dev;
    logic [64:0]        diff;
    // timestamp tracking runs for every format
    w.crossed = prev_ts > ts;
    w.delta   = ts - prev_ts;
    prev_ts   = ts;
    if (p_fmt == FMT_L16) begin
      bps = 64'd2;
    end else if (p_fmt == FMT_L24) begin
      bps = 64'd3;
    end else begin
      return 1'b0;
    end
    // window length in packets, saturated to the counter width
    if (fs == '0) begin
      win = 64'(WIN_MAX);
    end else begin
      num = 64'(p_rate) * 64'(p_chans) * bps;
      win = num / 64'(fs);
      if (win > 64'(WIN_MAX)) win = 64'(WIN_MAX);
    end
    raw   = {1'b0, pres} - {1'b0, trans};
    delay = $signed(raw);
    if (!win_open || 64'(win_count) == win) begin
      // window restart: publish max minus min, clamped to 63 bits
      if (dev_hi < dev_lo) begin
        tsdf_hold = '0;
      end else begin
        diff      = {dev_hi[63], dev_hi} - {dev_lo[63], dev_lo};
        tsdf_hold = diff[63] ? US_MAX : diff[62:0];
      end
      win_ref_delay = delay;
      win_open      = 1'b1;
      dev_hi        = S64_MIN;
      dev_lo        = S64_MAX;
      win_count     = WIN_W'(1);
      window_restarts++;
    end else begin
      // deviation from the window's first packet, saturated to 64 bits signed
      diff = {delay[63], delay} - {win_ref_delay[63], win_ref_delay};
      if (diff[64] != diff[63]) dev = diff[64] ? S64_MIN : S64_MAX;
      else dev = $signed(diff[63:0]);
      if (dev > dev_hi) dev_hi = dev;
      if (dev < dev_lo) dev_lo = dev;
      win_count = win_count + WIN_W'(1);
    end
    w.tsdf    = tsdf_hold;
    w.latency = $signed(raw);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------
  function automatic void add_row(input logic [CRATE_W-1:0] rate,
                                  input logic [CHAN_W-1:0] chans,
                                  input logic [FMT_W-1:0] fmt,
                                  input logic [US_W-1:0] pres,
                                  input logic [US_W-1:0] trans,
                                  input logic [TS_W-1:0] ts,
                                  input logic [FS_W-1:0] fs);
    packet_row_t row;
    row.rate  = rate;
    row.chans = chans;
    row.fmt   = fmt;
    row.pres  = pres;
    row.trans = trans;
    row.ts    = ts;
    row.fs    = fs;
    row.typed = 1'b0;
    row.want  = '{default: '0};
    packet_rows.push_back(row);
  endfunction

  // pins the word of the last row added
  function automatic void want_word(input logic [TS_W-1:0] delta, input logic crossed,
                                    input logic [US_W-1:0] tsdf,
                                    input logic [63:0] latency);
    packet_rows[$].typed        = 1'b1;
    packet_rows[$].want.delta   = delta;
    packet_rows[$].want.crossed = crossed;
    packet_rows[$].want.tsdf    = tsdf;
    packet_rows[$].want.latency = latency;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------

  // offers one packet word, waits for it to be taken and queues its expected word, if any
  task automatic send_packet(input logic [US_W-1:0] pres, input logic [US_W-1:0] trans,
                             input logic [TS_W-1:0] ts, input logic [FS_W-1:0] fs,
                             input bit typed, input tsdf_word_t typed_word,
                             output bit produced);
    tsdf_word_t word;
    // random burst of idle cycles in front of the word
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    presentation_us <= pres;
    transmission_us <= trans;
    rtp_timestamp   <= ts;
    frame_size      <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    packets_sent++;
    produced = predict_tsdf(pres, trans, ts, fs, word);
    if (produced) begin
      // the typed word replaces the predicted one; the predictor still advances
      if (typed) word = typed_word;
      pending_words.push_back(word);
      if (word.tsdf != '0) nonzero_tsdf++;
      if (word.crossed) epoch_wraps++;
    end
  endtask

  // sender stops and waits until every queued word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // drains, then waits SETTLE_CYCLES longer with the sender idle
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers back to back, only while the block is idle
  task automatic set_config(input logic [CRATE_W-1:0] rate,
                            input logic [CHAN_W-1:0] chans,
                            input logic [FMT_W-1:0] fmt);
    int unsigned slot;
    for (slot = 0; slot < 3; slot++) begin
      cfg_valid <= 1'b1;
      case (slot)
        0: begin
          cfg_index <= CFG_CLOCK_RATE;
          cfg_data  <= CFG_DATA_W'(rate);
        end
        1: begin
          cfg_index <= CFG_CHANNEL_COUNT;
          cfg_data  <= CFG_DATA_W'(chans);
        end
        default: begin
          cfg_index <= CFG_SAMPLE_FORMAT;
          cfg_data  <= CFG_DATA_W'(fmt);
        end
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    p_rate  = rate;
    p_chans = chans;
    p_fmt   = fmt;
    settings_used++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus a long hold when hold_token moves
  // ---------------------------------------------------------------------------
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned gap_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      gap_left  <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left  <= gap_left - 1;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
      // burst of stalled cycles, this one included
      gap_left  <= $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result check: every accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tsdf_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing expected", 64'(tsdf_us), '0);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (timestamp_delta !== want.delta)
          report_mismatch("timestamp_delta", 64'(timestamp_delta), 64'(want.delta));
        if (epoch_crossed !== want.crossed)
          report_mismatch("epoch_crossed", 64'(epoch_crossed), 64'(want.crossed));
        if (tsdf_us !== want.tsdf)
          report_mismatch("tsdf_us", 64'(tsdf_us), 64'(want.tsdf));
        if (latency_us !== want.latency)
          report_mismatch("latency_us", latency_us, want.latency);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles without any handshake
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    tsdf_word_t         no_word;
    bit                 produced;
    int unsigned        phase;
    int unsigned        n_items;
    int unsigned        k;
    int unsigned        kind;
    int unsigned        rand_words;
    int unsigned        win_goal;
    logic [CRATE_W-1:0] rate;
    logic [CHAN_W-1:0]  chans;
    logic [FMT_W-1:0]   fmt;
    logic [63:0]        num;
    logic [63:0]        fs_calc;
    logic [FS_W-1:0]    base_fs;
    logic [FS_W-1:0]    fs;
    logic [US_W-1:0]    trans;
    logic [US_W-1:0]    pres;
    logic [US_W-1:0]    base_lat;
    logic [US_W-1:0]    jitter;
    bit                 lat_neg;
    logic [TS_W-1:0]    ts;
    logic [TS_W-1:0]    ts_step;

    no_word = '{default: '0};
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part; under the reset setting (48 kHz, 2 ch, l24) a frame of
    // 65535 bytes gives a window of 4 packets
    // first packet opens a window and reports a delay factor of 0
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd1000, 63'd400, 32'd100, 16'hFFFF);
    want_word(32'd100, 1'b0, '0, 64'd600);
    // timestamp going down flags a crossing; largest positive latency
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, US_MAX, 63'd0, 32'd50, 16'hFFFF);
    want_word(32'hFFFF_FFCE, 1'b1, '0, {1'b0, US_MAX});
    // most negative latency, deviation saturates low
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd0, US_MAX, 32'hFFFF_FFFF, 16'hFFFF);
    // timestamp wraps past zero
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd5, 63'd5, 32'd0, 16'hFFFF);
    want_word(32'd1, 1'b1, '0, 64'd0);
    // window restart: max minus min overflows and clamps
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd0, 63'd0, 32'd0, 16'hFFFF);
    want_word(32'd0, 1'b0, US_MAX, 64'd0);
    // ordinary window with small deviations
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd2000, 63'd1000, 32'd480, 16'hFFFF);
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd3100, 63'd2000, 32'd960, 16'hFFFF);
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd3950, 63'd3000, 32'd1440, 16'hFFFF);
    // restart on a most negative reference delay
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd0, US_MAX, 32'd1920, 16'hFFFF);
    // zero frame size; deviation saturates high
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, US_MAX, 63'd0, 32'd2400, 16'h0000);
    // other format: timestamp tracked, no word, window untouched
    add_row(RESET_RATE, RESET_CHANS, FMT_OTHER, 63'd77, 63'd7, 32'd100, 16'd1);
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd10, 63'd20, 32'd50, 16'hFFFF);
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd30, 63'd20, 32'd60, 16'hFFFF);
    add_row(RESET_RATE, RESET_CHANS, FMT_L24, 63'd40, 63'd20, 32'd70, 16'hFFFF);
    // l16 with a one-packet window: windows without deviations report 0
    add_row(18'd40000, 7'd1, FMT_L16, 63'd7, 63'd2, 32'd80, 16'hFFFF);
    want_word(32'd10, 1'b0, '0, 64'd5);
    add_row(18'd40000, 7'd1, FMT_L16, 63'd9, 63'd2, 32'd90, 16'hFFFF);
    want_word(32'd10, 1'b0, '0, 64'd7);
    // zero window length: the count never matches again
    add_row(18'd1, 7'd1, FMT_L16, 63'd100, 63'd50, 32'd91, 16'd3);
    add_row(18'd1, 7'd1, FMT_L16, 63'd40, 63'd50, 32'd92, 16'hFFFF);
    // largest setting in range, then a quotient past the counter width
    add_row(18'd192000, 7'd64, FMT_L24, 63'd1, 63'd0, 32'd93, 16'd1);
    add_row(18'h3FFFF, 7'h7F, FMT_L24, 63'd0, 63'd1, 32'd94, 16'd1);
    // alternating bit patterns
    add_row(RESET_RATE, RESET_CHANS, FMT_L16, {32'h5555_5555, 31'h5555_5555},
            {32'h2AAA_AAAA, 31'h2AAA_AAAA}, 32'hAAAA_AAAA, 16'h5555);
    add_row(RESET_RATE, RESET_CHANS, FMT_L16, {32'h2AAA_AAAA, 31'h2AAA_AAAA},
            {32'h5555_5555, 31'h5555_5555}, 32'h5555_5555, 16'hAAAA);

    foreach (packet_rows[i]) begin
      if (packet_rows[i].rate != p_rate || packet_rows[i].chans != p_chans ||
          packet_rows[i].fmt != p_fmt) begin
        wait_idle();
        set_config(packet_rows[i].rate, packet_rows[i].chans, packet_rows[i].fmt);
      end
      send_packet(packet_rows[i].pres, packet_rows[i].trans, packet_rows[i].ts,
                  packet_rows[i].fs, packet_rows[i].typed, packet_rows[i].want, produced);
    end

    // random part: phases of one register setting each, mostly well-formed
    // streams whose frame size gives short windows, with some noise
    rand_words = 0;
    phase      = 0;
    while (rand_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 7))
        0:       rate = 18'd1;
        1:       rate = 18'd192000;
        2:       rate = 18'd8000;
        3:       rate = 18'd44100;
        4, 5:    rate = 18'd48000;
        6:       rate = 18'd96000;
        default: rate = CRATE_W'($urandom_range(1, 192000));
      endcase
      case ($urandom_range(0, 5))
        0:       chans = 7'd1;
        1:       chans = 7'd64;
        2, 3:    chans = 7'd2;
        4:       chans = 7'd8;
        default: chans = CHAN_W'($urandom_range(1, 64));
      endcase
      if ($urandom_range(0, 14) == 0) fmt = FMT_OTHER;
      else fmt = $urandom_range(0, 1) ? FMT_L24 : FMT_L16;
      // pressure phases need words to come out
      if (phase == 2 || phase == 4) fmt = FMT_L24;

      wait_idle();
      // the tail of the run has no idling on either side
      if (rand_words + 80 >= RANDOM_WORDS) begin
        idle_pct <= 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct <= 0;
          1:       idle_pct <= 5;
          2:       idle_pct <= 15;
          default: idle_pct <= 30;
        endcase
      end
      set_config(rate, chans, fmt);

      // frame size aimed at a window of 1 to 12 packets
      win_goal = $urandom_range(1, 12);
      num      = 64'(rate) * 64'(chans) * ((fmt == FMT_L16) ? 64'd2 : 64'd3);
      fs_calc  = num / 64'(win_goal);
      if (fs_calc == 0) fs_calc = 1;
      if (fs_calc > 64'hFFFF) fs_calc = 64'hFFFF;
      base_fs = FS_W'(fs_calc);

      trans    = {23'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
      base_lat = US_W'($urandom_range(0, 100000));
      lat_neg  = ($urandom_range(0, 3) == 0);
      ts       = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                             : 32'($urandom);
      ts_step  = TS_W'($urandom_range(1, 1024));
      n_items  = $urandom_range(20, 60);

      // long receiver hold while the sender keeps offering packets
      if (phase == 2) hold_token <= hold_token + 1;

      for (k = 0; k < n_items; k++) begin
        // sender pauses mid-phase until every word has come out
        if (phase == 4 && k == n_items / 2) wait_drained();
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
          // noise: every field fully random
          pres = US_W'({$urandom, $urandom});
          send_packet(pres, US_W'({$urandom, $urandom}), 32'($urandom),
                      16'($urandom), 1'b0, no_word, produced);
        end else begin
          trans  = trans + US_W'($urandom_range(100, 2000));
          jitter = US_W'($urandom_range(0, 5000));
          pres   = lat_neg ? trans - base_lat - jitter : trans + base_lat + jitter;
          ts     = (kind < 7) ? 32'($urandom) : ts + ts_step;
          if (kind < 12) begin
            case ($urandom_range(0, 3))
              0:       fs = 16'h0000;
              1:       fs = 16'd1;
              2:       fs = 16'hFFFF;
              default: fs = 16'($urandom);
            endcase
          end else begin
            fs = base_fs;
          end
          send_packet(pres, trans, ts, fs, 1'b0, no_word, produced);
        end
        if (produced) rand_words++;
      end
      phase++;
    end

    // wind down: all words out, then time for anything stray to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch("words never delivered", 64'(pending_words.size()), '0);

    $display("covered %0d packets over %0d register settings, %0d words checked",
             packets_sent, settings_used + 1, words_checked);
    $display("%0d window restarts, %0d nonzero delay factors, %0d epoch crossings",
             window_restarts, nonzero_tsdf, epoch_wraps);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
